@@ sv/liu_pkg.sv @@
// Shared types and constants for the linear interpolation upsampler.
package liu_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int FACTOR_WIDTH = 6;
   localparam int DIV_CNT_WIDTH = $clog2(SAMPLE_WIDTH);
   localparam logic [FACTOR_WIDTH-1:0] FACTOR_RESET = FACTOR_WIDTH'(16);

   // One gap (or lone tail point) handed from the front to the back.
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] prev;      // left point of the gap
      logic [SAMPLE_WIDTH-1:0] cur;       // right point, emitted on a tail
      logic [SAMPLE_WIDTH-1:0] quo_step;  // |cur - prev| / factor
      logic [FACTOR_WIDTH-1:0] rem_step;  // |cur - prev| % factor
      logic [FACTOR_WIDTH-1:0] factor;    // effective factor, never zero
      logic                    neg;       // cur < prev
      logic                    gap;       // emit the interpolated run
      logic                    last;      // emit cur as the final sample
   } cmd_type;

endpackage

@@ sv/linear_interp_upsampler_core.sv @@
// Top level of the linear interpolation upsampler.
//
//   channel  direction  handshake               payload
//   req      in         req_push / req_full     req_point_value, req_is_last_point
//   rsp      out        rsp_pop / rsp_empty     rsp_sample_value, rsp_last_of_run
//   csr      in         csr_wr_en               csr_wr_data (upsample_factor)
//
// A point that closes a gap holds the front through accept, the step divider (one
// quotient bit per cycle) and the hand-off to the queue, which waits while it is full.
// The back emits one sample per cycle while rsp is popped or empty: factor samples
// per gap, plus one on a last point.
// Reset is synchronous; upsample_factor returns to 16 and the stored point clears.
// req_full is high while the front divides or hands off; a stalled rsp side fills
// the output register and the two-entry queue, and then the front waits to hand off.
module linear_interp_upsampler_core import liu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [SAMPLE_WIDTH-1:0] req_point_value,
   input  logic                    req_is_last_point,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_value,
   output logic                    rsp_last_of_run,
   input  logic                    csr_wr_en,
   input  logic [FACTOR_WIDTH-1:0] csr_wr_data
);

   logic [FACTOR_WIDTH-1:0] factor_ff;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in_data, cmd_out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (csr_wr_en) begin
         factor_ff <= csr_wr_data;
      end
   end

   liu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_point_value   (req_point_value),
      .req_is_last_point (req_is_last_point),
      .factor            (factor_ff),
      .cmd_push          (cmd_push),
      .cmd_data          (cmd_in_data),
      .cmd_full          (cmd_full)
   );

   liu_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   liu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_data         (cmd_out_data),
      .cmd_empty        (cmd_empty),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sample_value (rsp_sample_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

@@ sv/liu_front.sv @@
// Front end: accepts points, keeps the previous point, divides the step size.
module liu_front import liu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [SAMPLE_WIDTH-1:0] req_point_value,
   input  logic                    req_is_last_point,
   input  logic [FACTOR_WIDTH-1:0] factor,
   output logic                    cmd_push,
   output cmd_type                 cmd_data,
   input  logic                    cmd_full
);

   typedef enum logic [1:0] {F_IDLE, F_DIVIDE, F_PUSH} front_state_type;

   front_state_type         state_ff, state_in;
   logic [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                    have_prev_ff, have_prev_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [FACTOR_WIDTH-1:0] rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic                    accept;
   logic [FACTOR_WIDTH-1:0] factor_eff;
   logic signed [SAMPLE_WIDTH:0] diff;
   logic [SAMPLE_WIDTH-1:0] diff_mag;
   logic [FACTOR_WIDTH:0]   shifted;
   logic [FACTOR_WIDTH:0]   trial;

   assign req_full = (state_ff != F_IDLE);
   assign accept   = req_push && !req_full;
   assign factor_eff = (factor == '0) ? FACTOR_WIDTH'(1) : factor;

   assign diff = $signed({req_point_value[SAMPLE_WIDTH-1], req_point_value})
               - $signed({prev_ff[SAMPLE_WIDTH-1], prev_ff});
   // magnitude of a difference of two samples always fits SAMPLE_WIDTH bits
   assign diff_mag = diff[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-diff) : diff[SAMPLE_WIDTH-1:0];

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[SAMPLE_WIDTH-1]};
   assign trial   = shifted - {1'b0, cmd_ff.factor};

   assign cmd_push = (state_ff == F_PUSH) && !cmd_full;
   always_comb begin
      cmd_data          = cmd_ff;
      cmd_data.quo_step = quo_ff;
      cmd_data.rem_step = rem_ff;
   end

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      cmd_in       = cmd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cmd_in.prev   = prev_ff;
               cmd_in.cur    = req_point_value;
               cmd_in.factor = factor_eff;
               cmd_in.neg    = diff[SAMPLE_WIDTH];
               cmd_in.gap    = have_prev_ff;
               cmd_in.last   = req_is_last_point;
               cmd_in.quo_step = '0;
               cmd_in.rem_step = '0;
               rem_in = '0;
               quo_in = diff_mag;
               cnt_in = DIV_CNT_WIDTH'(SAMPLE_WIDTH - 1);
               if (req_is_last_point) begin
                  prev_in      = '0;
                  have_prev_in = 1'b0;
               end else begin
                  prev_in      = req_point_value;
                  have_prev_in = 1'b1;
               end
               if (have_prev_ff) begin
                  state_in = F_DIVIDE;
               end else if (req_is_last_point) begin
                  state_in = F_PUSH;
               end
            end
         end
         F_DIVIDE: begin
            if (!trial[FACTOR_WIDTH]) begin
               rem_in = trial[FACTOR_WIDTH-1:0];
               quo_in = {quo_ff[SAMPLE_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = shifted[FACTOR_WIDTH-1:0];
               quo_in = {quo_ff[SAMPLE_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!cmd_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
      end
      cmd_ff <= cmd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

@@ sv/liu_cmd_fifo.sv @@
// Two-entry command queue between front and back.
module liu_cmd_fifo import liu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/liu_back.sv @@
// Back end: walks a gap one sample per cycle into the output register while it is empty or popped.
module liu_back import liu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd_data,
   input  logic                    cmd_empty,
   output logic                    cmd_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_value,
   output logic                    rsp_last_of_run
);

   typedef enum logic [1:0] {B_IDLE, B_GAP, B_TAIL} back_state_type;

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [SAMPLE_WIDTH-1:0] q_ff, q_in;
   logic [FACTOR_WIDTH-1:0] r_ff, r_in;
   logic [FACTOR_WIDTH-1:0] k_ff, k_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;
   logic                    out_last_ff, out_last_in;

   logic                    advance;
   logic                    final_k;
   logic [FACTOR_WIDTH:0]   r_sum;
   logic                    carry;
   logic signed [SAMPLE_WIDTH:0] interp;

   assign advance = !out_valid_ff || rsp_pop;
   assign cmd_pop = (state_ff == B_IDLE) && !cmd_empty;
   assign final_k = (k_ff == cmd_ff.factor - 1'b1);

   // running |diff|*k split as q*factor + r, with r kept below factor
   assign r_sum = {1'b0, r_ff} + {1'b0, cmd_ff.rem_step};
   assign carry = (r_sum >= {1'b0, cmd_ff.factor});
   assign interp = cmd_ff.neg
      ? $signed({cmd_ff.prev[SAMPLE_WIDTH-1], cmd_ff.prev}) - $signed({1'b0, q_ff})
      : $signed({cmd_ff.prev[SAMPLE_WIDTH-1], cmd_ff.prev}) + $signed({1'b0, q_ff});

   assign rsp_empty        = !out_valid_ff;
   assign rsp_sample_value = out_sample_ff;
   assign rsp_last_of_run  = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      q_in          = q_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_in   = cmd_data;
               q_in     = '0;
               r_in     = '0;
               k_in     = '0;
               state_in = cmd_data.gap ? B_GAP : B_TAIL;
            end
         end
         B_GAP: begin
            if (advance) begin
               out_valid_in  = 1'b1;
               out_sample_in = interp[SAMPLE_WIDTH-1:0];
               out_last_in   = !cmd_ff.last && final_k;
               q_in = q_ff + cmd_ff.quo_step + SAMPLE_WIDTH'(carry);
               r_in = carry ? FACTOR_WIDTH'(r_sum - {1'b0, cmd_ff.factor})
                            : r_sum[FACTOR_WIDTH-1:0];
               k_in = k_ff + 1'b1;
               if (final_k) begin
                  state_in = cmd_ff.last ? B_TAIL : B_IDLE;
               end
            end
         end
         B_TAIL: begin
            if (advance) begin
               out_valid_in  = 1'b1;
               out_sample_in = cmd_ff.cur;
               out_last_in   = 1'b1;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff        <= cmd_in;
      q_ff          <= q_in;
      r_ff          <= r_in;
      k_ff          <= k_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

endmodule

@@ sv/liu_checker.sv @@
// Port-level checks for the upsampler core, bound to the top level.
module liu_checker import liu_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_push,
   input logic                    req_full,
   input logic                    req_is_last_point,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_value,
   input logic                    rsp_last_of_run
);

   // nothing is waiting right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("rsp not empty after reset");

   // front is ready right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("req full after reset");

   // a waiting transaction stays put until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_sample_value)
                                    && $stable(rsp_last_of_run)))
      else $error("rsp transaction changed while stalled");

   // a first point that is not last produces nothing and leaves the front free
   a_lone_first: assert property (@(posedge clock)
      (reset ##1 (req_push && !req_full && !req_is_last_point)) |=> !req_full)
      else $error("front busy after storing the first point");

endmodule

bind linear_interp_upsampler_core liu_checker u_liu_checker (.*);

@@ verif/tb_linear_interp_upsampler_core.sv @@
// Self-checking testbench for the linear interpolation upsampler core.
module tb_linear_interp_upsampler_core import liu_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT      = 27;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = SAMPLE_WIDTH + 8;
   localparam int RANDOM_POINTS = 100;

   // Tracks the stored point and factor, and the samples each point must produce.
   class upsample_scoreboard;
      typedef struct {
         logic [SAMPLE_WIDTH-1:0] value;
         logic                    last;
      } sample_type;

      sample_type              samples_due[$];
      logic [FACTOR_WIDTH-1:0] factor;
      logic [SAMPLE_WIDTH-1:0] held_point;
      bit                      have_point;
      int                      mismatches;
      int                      points_taken;
      int                      samples_checked;

      function new();
         factor          = FACTOR_RESET;
         held_point      = '0;
         have_point      = 1'b0;
         mismatches      = 0;
         points_taken    = 0;
         samples_checked = 0;
      endfunction

      function int pending();
         return samples_due.size();
      endfunction

      function void set_factor(logic [FACTOR_WIDTH-1:0] value);
         factor = value;
      endfunction

      function void queue_sample(int value, bit last);
         sample_type s;
         s.value = SAMPLE_WIDTH'(value);
         s.last  = last;
         samples_due.push_back(s);
      endfunction

      function void take_point(logic [SAMPLE_WIDTH-1:0] point, logic last);
         int cur;
         int prev;
         int span;
         int steps;
         cur   = int'($signed(point));
         prev  = int'($signed(held_point));
         span  = cur - prev;
         // a zero factor behaves as one: only the left point of the gap
         steps = (factor == '0) ? 1 : int'(factor);
         points_taken++;
         if (have_point) begin
            queue_sample(prev, !last && steps == 1);
            // int division truncates toward zero
            for (int k = 1; k < steps; k++)
               queue_sample(prev + span * k / steps, !last && k == steps - 1);
         end
         if (last) begin
            queue_sample(cur, 1'b1);
            held_point = '0;
            have_point = 1'b0;
         end else begin
            held_point = point;
            have_point = 1'b1;
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_sample(logic [SAMPLE_WIDTH-1:0] value, logic last);
         sample_type want;
         if (samples_due.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d last %b", $signed(value), last));
            return;
         end
         want = samples_due.pop_front();
         samples_checked++;
         if (value !== want.value)
            report_mismatch($sformatf("sample %0d: value %0d, want %0d", samples_checked,
                                      $signed(value), $signed(want.value)));
         if (last !== want.last)
            report_mismatch($sformatf("sample %0d: last_of_run %b, want %b", samples_checked,
                                      last, want.last));
      endtask
   endclass

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_push          = 1'b0;
   logic                    req_full;
   logic [SAMPLE_WIDTH-1:0] req_point_value   = '0;
   logic                    req_is_last_point = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop           = 1'b0;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_value;
   logic                    rsp_last_of_run;
   logic                    csr_wr_en         = 1'b0;
   logic [FACTOR_WIDTH-1:0] csr_wr_data       = '0;

   upsample_scoreboard sb = new();
   bit                 steady;
   int                 hold_pop_cycles;
   int                 full_cycles;
   int                 factor_writes;

   linear_interp_upsampler_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_point_value   (req_point_value),
      .req_is_last_point (req_is_last_point),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Transaction monitor on both channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.take_point(req_point_value, req_is_last_point);
         if (req_push && req_full)
            full_cycles++;
         if (rsp_pop && !rsp_empty)
            sb.check_sample(rsp_sample_value, rsp_last_of_run);
      end
   end

   // Result side: random pops, with an occasional long hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_pop_cycles > 0) begin
            rsp_pop <= 1'b0;
            hold_pop_cycles--;
         end else if (steady) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task send_point(logic [SAMPLE_WIDTH-1:0] value, logic last);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_point_value   <= value;
      req_is_last_point <= last;
      do @(posedge clock); while (req_full !== 1'b0);
   endtask

   // Stop offering and let every expected sample come out, then let the front settle.
   task drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_factor(logic [FACTOR_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_factor(value);
      factor_writes++;
      csr_wr_en   <= 1'b0;
   endtask

   function logic [SAMPLE_WIDTH-1:0] random_point();
      // mostly within +-1.0 in Q1.14, sometimes any 16-bit pattern
      if ($urandom_range(7) == 0)
         return SAMPLE_WIDTH'($urandom);
      return SAMPLE_WIDTH'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   initial begin
      int sent;
      int phase;
      int run_len;
      int phase_points;
      bit close_run;
      logic [FACTOR_WIDTH-1:0] f;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // factor at its reset value: lone last point, full-scale swings, widest span
      send_point(16'h4000, 1'b1);
      send_point(SAMPLE_WIDTH'(-16384), 1'b0);
      send_point(SAMPLE_WIDTH'(16384), 1'b0);
      send_point(SAMPLE_WIDTH'(-16384), 1'b1);
      send_point(16'h7fff, 1'b0);
      send_point(16'h8000, 1'b1);
      drain();
      write_factor(FACTOR_WIDTH'(1));
      send_point(SAMPLE_WIDTH'(100), 1'b0);
      send_point(SAMPLE_WIDTH'(-100), 1'b0);
      send_point(SAMPLE_WIDTH'(5), 1'b1);
      drain();
      write_factor(FACTOR_WIDTH'(0));
      send_point(SAMPLE_WIDTH'(7), 1'b0);
      send_point(SAMPLE_WIDTH'(-7), 1'b1);
      drain();
      write_factor(FACTOR_WIDTH'(63));
      send_point(SAMPLE_WIDTH'(-16384), 1'b0);
      send_point(SAMPLE_WIDTH'(16384), 1'b1);
      send_point(SAMPLE_WIDTH'(1), 1'b0);
      send_point(SAMPLE_WIDTH'(0), 1'b1);
      drain();
      // negative steps truncate toward zero
      write_factor(FACTOR_WIDTH'(3));
      send_point(SAMPLE_WIDTH'(0), 1'b0);
      send_point(SAMPLE_WIDTH'(-5), 1'b0);
      send_point(SAMPLE_WIDTH'(5), 1'b1);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_POINTS) begin
         phase++;
         drain();
         if ($urandom_range(11) == 0)
            f = '0;
         else if ($urandom_range(5) == 0)
            f = FACTOR_WIDTH'($urandom_range(13, 63));
         else
            f = FACTOR_WIDTH'($urandom_range(1, 12));
         write_factor(f);
         steady = (phase == 3);
         if (phase == 2)
            hold_pop_cycles = HOLD_CYCLES;
         phase_points = 0;
         while (phase_points < 15 && sent < RANDOM_POINTS) begin
            run_len   = $urandom_range(1, 5);
            // now and then a curve runs on past its usual end
            close_run = ($urandom_range(9) != 0);
            for (int i = 0; i < run_len; i++) begin
               send_point(random_point(), close_run && i == run_len - 1);
               sent++;
               phase_points++;
            end
         end
         steady = 1'b0;
      end
      drain();

      $display("covered %0d points and %0d samples over %0d factor settings",
               sb.points_taken, sb.samples_checked, factor_writes);
      $display("input held off by a full block for %0d cycles", full_cycles);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d samples outstanding", sb.pending());
      $display("FAIL");
      $finish;
   end

endmodule
